FILE: rtl/qpm_pkg.sv
// Shared constants, types and the divider step for the quaternion to pose matrix pipeline.
package qpm_pkg;

	localparam int QB      = 25;  // quotient bits resolved by the divider pipeline
	localparam int DEN_W   = 33;  // width of the squared norm
	localparam int NUM_W   = 34;  // width of a signed matrix numerator
	localparam int OFF_W   = 24;
	localparam int MAT_W   = 18;
	localparam int FRAC    = 16;
	localparam int LANES   = 12;  // nine matrix entries, three translation terms
	localparam int MLANES  = 9;
	localparam int DIV_W   = DEN_W + QB;

	localparam logic signed [MAT_W-1:0] ONE_Q16   = 18'sd65536;
	localparam logic signed [OFF_W-1:0] SHIFT_MAX = 24'sd8388607;

	typedef logic [DEN_W-1:0] den_t;
	typedef logic [QB-1:0]    dq_t;

	typedef struct packed {
		den_t rem;
		dq_t  dq;   // low dividend bits shift out at the top, quotient bits enter at the bottom
	} lane_t;

	typedef struct packed {
		logic             zero;
		logic [LANES-1:0] neg;
		den_t             den;
		lane_t [LANES-1:0] lane;
	} dstage_t;

	function automatic lane_t div_step(lane_t a, den_t den);
		logic [DEN_W:0] trial;
		lane_t          r;
		trial = {a.rem, a.dq[QB-1]};
		if (trial >= {1'b0, den}) begin
			r.rem = DEN_W'(trial - {1'b0, den});
			r.dq  = {a.dq[QB-2:0], 1'b1};
		end else begin
			r.rem = trial[DEN_W-1:0];
			r.dq  = {a.dq[QB-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic dstage_t div_all(dstage_t a);
		dstage_t r;
		r = a;
		for (int i = 0; i < LANES; i++) begin
			r.lane[i] = div_step(a.lane[i], a.den);
		end
		return r;
	endfunction

endpackage

FILE: rtl/quaternion_to_pose_matrix.sv
// Top level: pipelined quaternion normalization into a rotation matrix and translation column.
// A result leaves on done after the product, norm, divider-load, divider and output registers.
// Throughput: one item per cycle; busy stays low and every start beat is taken.
// The depth is set by the 25-stage restoring divider, one quotient bit per stage, 12 lanes.
// Reset clears every valid bit at once; no result appears until new beats arrive.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module quaternion_to_pose_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [23:0] pivot_offset,
	output logic               done,
	output logic signed [17:0] r00,
	output logic signed [17:0] r01,
	output logic signed [17:0] r02,
	output logic signed [17:0] r10,
	output logic signed [17:0] r11,
	output logic signed [17:0] r12,
	output logic signed [17:0] r20,
	output logic signed [17:0] r21,
	output logic signed [17:0] r22,
	output logic signed [23:0] shift_x,
	output logic signed [23:0] shift_y,
	output logic signed [23:0] shift_z
);
	import qpm_pkg::*;

	// stage 1: products
	logic                    v_s1;
	logic signed [31:0]      ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [31:0]      xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [OFF_W-1:0] off_s1;

	// stage 2: norm and numerators
	logic                    v_s2;
	den_t                    den_s2;
	logic signed [NUM_W-1:0] num_s2 [MLANES];
	logic signed [OFF_W-1:0] off_s2;

	// stage 3: dividend magnitudes loaded into the divider form
	logic                    v_s3;
	dstage_t                 st_s3;
	dstage_t                 st_c;

	// divider: entry k is stage 4+k
	dstage_t                 dv_s4 [QB];
	logic [QB-1:0]           dvv_s4;

	logic                    done_q;
	logic signed [MAT_W-1:0] rm_q [MLANES];
	logic signed [OFF_W-1:0] sh_q [3];
	logic signed [MAT_W-1:0] rm_c [MLANES];
	logic signed [OFF_W-1:0] sh_c [3];

	den_t                    n2_c;
	logic signed [35:0]      ne_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			dvv_s4 <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			dvv_s4 <= {dvv_s4[QB-2:0], v_s3};
			done_q <= dvv_s4[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		ww_s1  <= quat_w * quat_w;
		xx_s1  <= quat_x * quat_x;
		yy_s1  <= quat_y * quat_y;
		zz_s1  <= quat_z * quat_z;
		xy_s1  <= quat_x * quat_y;
		wz_s1  <= quat_w * quat_z;
		xz_s1  <= quat_x * quat_z;
		wy_s1  <= quat_w * quat_y;
		yz_s1  <= quat_y * quat_z;
		wx_s1  <= quat_w * quat_x;
		off_s1 <= pivot_offset;
	end

	always_comb begin
		n2_c = DEN_W'($unsigned(ww_s1)) + DEN_W'($unsigned(xx_s1))
			+ DEN_W'($unsigned(yy_s1)) + DEN_W'($unsigned(zz_s1));
		ne_c = $signed({3'b000, n2_c});
	end

	always_ff @(posedge clk) begin
		den_s2    <= n2_c;
		off_s2    <= off_s1;
		num_s2[0] <= NUM_W'(ne_c - 36'sd2 * (36'(yy_s1) + 36'(zz_s1)));
		num_s2[1] <= NUM_W'(36'sd2 * (36'(xy_s1) - 36'(wz_s1)));
		num_s2[2] <= NUM_W'(36'sd2 * (36'(xz_s1) + 36'(wy_s1)));
		num_s2[3] <= NUM_W'(36'sd2 * (36'(xy_s1) + 36'(wz_s1)));
		num_s2[4] <= NUM_W'(ne_c - 36'sd2 * (36'(xx_s1) + 36'(zz_s1)));
		num_s2[5] <= NUM_W'(36'sd2 * (36'(yz_s1) - 36'(wx_s1)));
		num_s2[6] <= NUM_W'(36'sd2 * (36'(xz_s1) - 36'(wy_s1)));
		num_s2[7] <= NUM_W'(36'sd2 * (36'(yz_s1) + 36'(wx_s1)));
		num_s2[8] <= NUM_W'(ne_c - 36'sd2 * (36'(xx_s1) + 36'(yy_s1)));
	end

	// dividend is twice the magnitude, so the quotient keeps one bit for rounding
	always_comb begin
		logic [DEN_W-1:0] mag [MLANES];
		logic [OFF_W-1:0] offm;
		logic [DIV_W-1:0] d;
		offm = off_s2[OFF_W-1] ? OFF_W'(-off_s2) : OFF_W'(off_s2);
		st_c.zero = (den_s2 == '0);
		st_c.den  = den_s2;
		for (int i = 0; i < MLANES; i++) begin
			mag[i] = num_s2[i][NUM_W-1] ? DEN_W'(-num_s2[i]) : DEN_W'(num_s2[i]);
			d = DIV_W'(mag[i]) << (FRAC + 1);
			st_c.neg[i]      = num_s2[i][NUM_W-1];
			st_c.lane[i].rem = d[DIV_W-1:QB];
			st_c.lane[i].dq  = d[QB-1:0];
		end
		for (int j = 0; j < 3; j++) begin
			d = DIV_W'({DIV_W'(mag[3*j+2]) * DIV_W'(offm), 1'b0});
			st_c.neg[MLANES+j]      = num_s2[3*j+2][NUM_W-1] ^ off_s2[OFF_W-1];
			st_c.lane[MLANES+j].rem = d[DIV_W-1:QB];
			st_c.lane[MLANES+j].dq  = d[QB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		st_s3    <= st_c;
		dv_s4[0] <= div_all(st_s3);
		for (int k = 1; k < QB; k++) begin
			dv_s4[k] <= div_all(dv_s4[k-1]);
		end
	end

	// round half away from zero, restore sign, clamp the translation; a zero norm gives identity and no shift
	always_comb begin
		logic [QB-1:0] qr;
		dstage_t       lst;
		lst = dv_s4[QB-1];
		for (int i = 0; i < MLANES; i++) begin
			qr = QB'(({1'b0, lst.lane[i].dq} + (QB+1)'(1)) >> 1);
			if (lst.zero) begin
				rm_c[i] = (i % 4 == 0) ? ONE_Q16 : '0;
			end else begin
				rm_c[i] = lst.neg[i] ? -MAT_W'(qr) : MAT_W'(qr);
			end
		end
		for (int j = 0; j < 3; j++) begin
			qr = QB'(({1'b0, lst.lane[MLANES+j].dq} + (QB+1)'(1)) >> 1);
			if (lst.zero) begin
				sh_c[j] = '0;
			end else if (!lst.neg[MLANES+j] && qr > QB'(SHIFT_MAX)) begin
				sh_c[j] = SHIFT_MAX;
			end else begin
				sh_c[j] = lst.neg[MLANES+j] ? -OFF_W'(qr) : OFF_W'(qr);
			end
		end
	end

	always_ff @(posedge clk) begin
		rm_q <= rm_c;
		sh_q <= sh_c;
	end

	assign done    = done_q;
	assign r00     = rm_q[0];
	assign r01     = rm_q[1];
	assign r02     = rm_q[2];
	assign r10     = rm_q[3];
	assign r11     = rm_q[4];
	assign r12     = rm_q[5];
	assign r20     = rm_q[6];
	assign r21     = rm_q[7];
	assign r22     = rm_q[8];
	assign shift_x = sh_q[0];
	assign shift_y = sh_q[1];
	assign shift_z = sh_q[2];

`ifndef SYNTH
	logic rem_ok;
	always_comb begin
		rem_ok = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			if (dv_s4[QB-1].lane[i].rem >= dv_s4[QB-1].den) begin
				rem_ok = 1'b0;
			end
		end
	end

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		dvv_s4[QB-1] && !dv_s4[QB-1].zero |-> rem_ok)
		else $error("divider remainder not below norm");

	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		dvv_s4[QB-1] && dv_s4[QB-1].zero |=> done && r00 == ONE_Q16 && r11 == ONE_Q16
			&& r22 == ONE_Q16 && r01 == 18'sd0 && shift_x == 24'sd0 && shift_z == 24'sd0)
		else $error("zero quaternion did not give identity");

	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> r00 <= ONE_Q16 && r00 >= -ONE_Q16 && r11 <= ONE_Q16 && r11 >= -ONE_Q16
			&& r22 <= ONE_Q16 && r22 >= -ONE_Q16)
		else $error("matrix entry out of range");
`endif

endmodule
